[rtl/hfsm_pkg.sv]
// Shared types and constants of the heartbeat frame and slot monitor.
package hfsm_pkg;

	localparam int unsigned SlotMax     = 16;
	localparam int unsigned FrameLength = 17;
	localparam int unsigned PosWidth    = 5;

	// Fixed datagram bytes.
	localparam logic [7:0] FlagByte    = 8'hEF;
	localparam logic [7:0] FlagEndByte = 8'h00;
	localparam logic [7:0] CmdByte0    = 8'hFF;
	localparam logic [7:0] CmdByte1    = 8'h16;

	// Byte positions of interest inside a datagram.
	localparam logic [PosWidth-1:0] PosFlag0   = 5'd0;
	localparam logic [PosWidth-1:0] PosFlag1   = 5'd1;
	localparam logic [PosWidth-1:0] PosFlagEnd = 5'd2;
	localparam logic [PosWidth-1:0] PosCmd0    = 5'd7;
	localparam logic [PosWidth-1:0] PosCmd1    = 5'd8;
	localparam logic [PosWidth-1:0] PosHdrLast = 5'd10;
	localparam logic [PosWidth-1:0] PosHdrSum  = 5'd11;
	localparam logic [PosWidth-1:0] PosSlotsHi = 5'd12;
	localparam logic [PosWidth-1:0] PosSlotsLo = 5'd13;
	localparam logic [PosWidth-1:0] PosSumLast = 5'd15;
	localparam logic [PosWidth-1:0] PosSum     = 5'd16;
	localparam logic [PosWidth-1:0] PosEnd     = 5'd17;
	localparam logic [PosWidth-1:0] MinFlagLen = 5'd2;
	localparam logic [PosWidth-1:0] MinCmdLen  = 5'd9;

	typedef enum logic [2:0] {
		KIND_NONE    = 3'd0,
		KIND_FRAME   = 3'd1,
		KIND_CHANGES = 3'd2,
		KIND_REFRESH = 3'd3,
		KIND_QUIET   = 3'd4
	} report_kind_t;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_FLAG    = 3'd1,
		STAT_CMD     = 3'd2,
		STAT_HDR_SUM = 3'd3,
		STAT_SUM     = 3'd4
	} frame_status_t;

	// Verdict of the datagram that ends with the current word.
	typedef struct packed {
		logic              pass;
		frame_status_t     status;
		logic [SlotMax-1:0] alive_bits;
	} frame_verdict_t;

endpackage

[rtl/heartbeat_frame_slot_monitor.sv]
// Top level of the heartbeat frame and slot monitor.
//
// The monitor takes one word per cycle on the input stream while the sink keeps
// up and returns exactly one word per input word on the output stream, so a
// word may follow its predecessor in the very next cycle. The input word is
// registered, then the datagram checker and the slot update logic evaluate it
// against the current state in a single pass and write the output register.
// A frame word (tuser bit 0 low) carries one datagram byte; the word with tlast
// high yields a frame verdict, and a passing datagram marks slots alive until
// the next tick. A tick word (tuser bit 0 high) compares every monitored slot
// with the state it last reported, reports newly alive and newly lost slots,
// optionally reports the full status when nothing changed and a refresh is
// due, and then forgets the current alive state. The output register is
// released as soon as the sink takes it, so a stalled sink stalls the input
// only after both registers are full. enabled_slots must be written through the
// configuration port while the stream is idle; the block does not enforce it.
module heartbeat_frame_slot_monitor
	import hfsm_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        enabled_slots_wr_en,
	input  logic [15:0] enabled_slots_wr_data,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // frame_byte
	input  logic        s_axis_tlast,  // last_of_frame
	input  logic [2:0]  s_axis_tuser,  // opcode, first_of_frame, refresh_due

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // frame_status, ok_mask, fail_mask,
	                                   // alarm_allowed, zero padding
	output logic [2:0]  m_axis_tuser   // report_kind
);

	localparam logic [SlotMax:0] SlotMaskWide =
		(({{SlotMax{1'b0}}, 1'b1}) << NUM_SLOTS) - {{SlotMax{1'b0}}, 1'b1};
	localparam logic [SlotMax-1:0] SlotMask = SlotMaskWide[SlotMax-1:0];

	// Input register.
	logic       valid_s1;
	logic       opcode_s1, first_s1, last_s1, refresh_s1;
	logic [7:0] byte_s1;

	// Output register.
	logic               valid_s2;
	report_kind_t       kind_s2;
	frame_status_t      status_s2;
	logic [SlotMax-1:0] ok_s2, fail_s2;
	logic               alarm_s2;

	// Monitor state.
	logic [15:0]        enabled_q;
	logic [SlotMax-1:0] alive_q;
	logic [SlotMax-1:0] reported_q;
	logic               first_tick_q;

	logic               advance;
	logic               take_byte;
	frame_verdict_t     verdict;
	logic [SlotMax-1:0] mon, ok_chg, fail_chg, reported_n;
	report_kind_t       kind_n;
	frame_status_t      status_n;
	logic [SlotMax-1:0] ok_n, fail_n;
	logic               alarm_n;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign take_byte     = advance && !opcode_s1;

	hfsm_frame_chk u_frame_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take_byte),
		.frame_byte (byte_s1),
		.first      (first_s1),
		.last       (last_s1),
		.verdict    (verdict)
	);

	always_comb begin
		mon        = enabled_q & SlotMask;
		// A reported slot that is not alive now is lost; the reverse is new.
		fail_chg   = mon & reported_q & ~alive_q;
		ok_chg     = mon & ~reported_q & alive_q;
		reported_n = (reported_q & ~fail_chg) | ok_chg;

		kind_n   = KIND_NONE;
		status_n = STAT_OK;
		ok_n     = '0;
		fail_n   = '0;
		alarm_n  = 1'b0;

		if (!opcode_s1) begin
			if (last_s1) begin
				kind_n   = KIND_FRAME;
				status_n = verdict.status;
			end
		end else begin
			alarm_n = !first_tick_q;
			if (ok_chg != '0 || fail_chg != '0) begin
				kind_n = KIND_CHANGES;
				ok_n   = ok_chg;
				fail_n = fail_chg;
			end else if (refresh_s1 && mon != '0) begin
				kind_n = KIND_REFRESH;
				ok_n   = mon & reported_q;
				fail_n = mon & ~reported_q;
			end else begin
				kind_n = KIND_QUIET;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= '0;
		end else if (enabled_slots_wr_en) begin
			enabled_q <= enabled_slots_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q      <= '0;
			reported_q   <= '0;
			first_tick_q <= 1'b1;
		end else if (advance) begin
			if (opcode_s1) begin
				alive_q      <= '0;
				reported_q   <= reported_n;
				first_tick_q <= 1'b0;
			end else if (verdict.pass) begin
				// Alive is sticky until the next tick.
				alive_q <= alive_q | verdict.alive_bits;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			opcode_s1  <= s_axis_tuser[0];
			first_s1   <= s_axis_tuser[1];
			refresh_s1 <= s_axis_tuser[2];
			last_s1    <= s_axis_tlast;
			byte_s1    <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s2   <= kind_n;
			status_s2 <= status_n;
			ok_s2     <= ok_n;
			fail_s2   <= fail_n;
			alarm_s2  <= alarm_n;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = kind_s2;
	assign m_axis_tdata  = {4'b0000, alarm_s2, fail_s2, ok_s2, status_s2};

endmodule

[rtl/hfsm_frame_chk.sv]
// Datagram accumulator and checker: running sums, captured bytes and verdict.
module hfsm_frame_chk
	import hfsm_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic [7:0]     frame_byte,
	input  logic           first,
	input  logic           last,
	output frame_verdict_t verdict
);

	logic [PosWidth-1:0] pos_q;
	logic [7:0]          hdr_sum_q;
	logic [7:0]          tot_sum_q;
	logic [7:0]          b11_q, b12_q, b13_q, b16_q;
	logic [1:0]          hdr_match_q;

	logic [PosWidth-1:0] pos_e, pos_n;
	logic [7:0]          hdr_sum_e, tot_sum_e, hdr_sum_n, tot_sum_n;
	logic [7:0]          b11_e, b12_e, b13_e, b16_e;
	logic [7:0]          b11_n, b12_n, b13_n, b16_n;
	logic [1:0]          hm_e, hm_n;
	logic                in_range;

	always_comb begin
		// A first word discards whatever was gathered before it.
		pos_e     = first ? '0 : pos_q;
		hdr_sum_e = first ? '0 : hdr_sum_q;
		tot_sum_e = first ? '0 : tot_sum_q;
		b11_e     = first ? '0 : b11_q;
		b12_e     = first ? '0 : b12_q;
		b13_e     = first ? '0 : b13_q;
		b16_e     = first ? '0 : b16_q;
		hm_e      = first ? '0 : hdr_match_q;

		in_range  = pos_e < PosEnd;
		pos_n     = in_range ? pos_e + 5'd1 : pos_e;
		hdr_sum_n = hdr_sum_e;
		tot_sum_n = tot_sum_e;
		b11_n     = b11_e;
		b12_n     = b12_e;
		b13_n     = b13_e;
		b16_n     = b16_e;
		hm_n      = hm_e;

		if (in_range) begin
			if ((pos_e == PosFlag0 || pos_e == PosFlag1) && frame_byte != FlagByte)
				hm_n[0] = 1'b1;
			if (pos_e == PosFlagEnd && frame_byte != FlagEndByte)
				hm_n[0] = 1'b1;
			if (pos_e == PosCmd0 && frame_byte != CmdByte0)
				hm_n[1] = 1'b1;
			if (pos_e == PosCmd1 && frame_byte != CmdByte1)
				hm_n[1] = 1'b1;
			if (pos_e <= PosHdrLast)
				hdr_sum_n = hdr_sum_e + frame_byte;
			if (pos_e <= PosSumLast)
				tot_sum_n = tot_sum_e + frame_byte;
			if (pos_e == PosHdrSum)
				b11_n = frame_byte;
			if (pos_e == PosSlotsHi)
				b12_n = frame_byte;
			if (pos_e == PosSlotsLo)
				b13_n = frame_byte;
			if (pos_e == PosSum)
				b16_n = frame_byte;
		end

		// Checks in priority order; missing bytes already count as zero.
		if (hm_n[0] || pos_n < MinFlagLen)
			verdict.status = STAT_FLAG;
		else if (hm_n[1] || pos_n < MinCmdLen)
			verdict.status = STAT_CMD;
		else if (hdr_sum_n != b11_n)
			verdict.status = STAT_HDR_SUM;
		else if (tot_sum_n != b16_n)
			verdict.status = STAT_SUM;
		else
			verdict.status = STAT_OK;

		verdict.pass       = last && (verdict.status == STAT_OK);
		// Slots 1-8 come from byte 13, slots 9-16 from byte 12.
		verdict.alive_bits = {b12_n, b13_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			hdr_sum_q   <= '0;
			tot_sum_q   <= '0;
			b11_q       <= '0;
			b12_q       <= '0;
			b13_q       <= '0;
			b16_q       <= '0;
			hdr_match_q <= '0;
		end else if (take) begin
			if (last) begin
				pos_q       <= '0;
				hdr_sum_q   <= '0;
				tot_sum_q   <= '0;
				b11_q       <= '0;
				b12_q       <= '0;
				b13_q       <= '0;
				b16_q       <= '0;
				hdr_match_q <= '0;
			end else begin
				pos_q       <= pos_n;
				hdr_sum_q   <= hdr_sum_n;
				tot_sum_q   <= tot_sum_n;
				b11_q       <= b11_n;
				b12_q       <= b12_n;
				b13_q       <= b13_n;
				b16_q       <= b16_n;
				hdr_match_q <= hm_n;
			end
		end
	end

endmodule

[sim/heartbeat_frame_slot_monitor_check.sv]
// Stream watcher that predicts every report word of the heartbeat monitor and compares it.
module heartbeat_frame_slot_monitor_check
	import hfsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        enabled_slots_wr_en,
	input  logic [15:0] enabled_slots_wr_data,

	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // frame_byte
	input  logic        s_axis_tlast,  // last_of_frame
	input  logic [2:0]  s_axis_tuser,  // opcode, first_of_frame, refresh_due

	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,  // frame_status, ok_mask, fail_mask,
	                                   // alarm_allowed, zero padding
	input  logic [2:0]  m_axis_tuser,  // report_kind

	output int          mismatch_count,
	output int          reports_owed
);

	localparam logic [1:0] SlotDead    = 2'd0;
	localparam logic [1:0] SlotAlive   = 2'd1;
	localparam logic [1:0] SlotUnknown = 2'd2;

	typedef struct {
		report_kind_t  kind;
		frame_status_t status;
		logic [15:0]   ok_slots;
		logic [15:0]   lost_slots;
		logic          alarm_allowed;
	} slot_report_t;

	slot_report_t         awaited_reports[$];

	logic [15:0]          monitored;
	logic [1:0]           slot_state [SlotMax];
	logic [15:0]          reported_alive;
	logic [PosWidth-1:0]  byte_pos;
	logic [7:0]           hdr_sum;
	logic [7:0]           full_sum;
	logic [31:0]          captured;
	logic                 flag_bad;
	logic                 cmd_bad;
	logic                 no_tick_yet;

	task automatic clear_datagram();
		byte_pos = '0;
		hdr_sum  = '0;
		full_sum = '0;
		captured = '0;
		flag_bad = 1'b0;
		cmd_bad  = 1'b0;
	endtask

	task automatic absorb_byte(input logic [PosWidth-1:0] pos, input logic [7:0] b);
		if ((pos == PosFlag0 || pos == PosFlag1) && b != FlagByte) flag_bad = 1'b1;
		if (pos == PosFlagEnd && b != FlagEndByte) flag_bad = 1'b1;
		if (pos == PosCmd0 && b != CmdByte0) cmd_bad = 1'b1;
		if (pos == PosCmd1 && b != CmdByte1) cmd_bad = 1'b1;
		if (pos <= PosHdrLast) hdr_sum = hdr_sum + b;
		if (pos <= PosSumLast) full_sum = full_sum + b;
		case (pos)
			PosHdrSum: captured[7:0] = b;
			PosSlotsHi: captured[15:8] = b;
			PosSlotsLo: captured[23:16] = b;
			PosSum: captured[31:24] = b;
			default: ;
		endcase
	endtask

	// Missing bytes count as zero, so a datagram cut short fails on the flag or
	// command check when those bytes never arrived.
	task automatic judge_datagram(output frame_status_t verdict);
		if (flag_bad || byte_pos < MinFlagLen) verdict = STAT_FLAG;
		else if (cmd_bad || byte_pos < MinCmdLen) verdict = STAT_CMD;
		else if (hdr_sum != captured[7:0]) verdict = STAT_HDR_SUM;
		else if (full_sum != captured[31:24]) verdict = STAT_SUM;
		else begin
			verdict = STAT_OK;
			// Alive is sticky until the next tick.
			for (int i = 0; i < 8; i++) begin
				if (slot_state[i] != SlotAlive)
					slot_state[i] = captured[16+i] ? SlotAlive : SlotDead;
				if (slot_state[i+8] != SlotAlive)
					slot_state[i+8] = captured[8+i] ? SlotAlive : SlotDead;
			end
		end
	endtask

	task automatic predict_report(input logic is_tick, input logic [7:0] b,
		input logic opens_frame, input logic is_last, input logic refresh,
		output slot_report_t r);
		logic [15:0]   ok_slots;
		logic [15:0]   lost_slots;
		frame_status_t verdict;
		r.kind          = KIND_NONE;
		r.status        = STAT_OK;
		r.ok_slots      = '0;
		r.lost_slots    = '0;
		r.alarm_allowed = 1'b0;
		if (!is_tick) begin
			if (opens_frame) clear_datagram();
			if (byte_pos < PosEnd) begin
				absorb_byte(byte_pos, b);
				byte_pos = byte_pos + 1'b1;
			end
			if (is_last) begin
				judge_datagram(verdict);
				r.kind   = KIND_FRAME;
				r.status = verdict;
				clear_datagram();
			end
		end else begin
			ok_slots   = '0;
			lost_slots = '0;
			for (int i = 0; i < SlotMax; i++) begin
				if (monitored[i]) begin
					if (reported_alive[i] && slot_state[i] != SlotAlive) begin
						lost_slots[i]     = 1'b1;
						reported_alive[i] = 1'b0;
					end else if (!reported_alive[i] && slot_state[i] == SlotAlive) begin
						ok_slots[i]       = 1'b1;
						reported_alive[i] = 1'b1;
					end
				end
				slot_state[i] = SlotUnknown;
			end
			if (ok_slots != '0 || lost_slots != '0) begin
				r.kind = KIND_CHANGES;
			end else if (refresh && monitored != '0) begin
				r.kind     = KIND_REFRESH;
				ok_slots   = monitored & reported_alive;
				lost_slots = monitored & ~reported_alive;
			end else begin
				r.kind = KIND_QUIET;
			end
			r.ok_slots      = ok_slots;
			r.lost_slots    = lost_slots;
			r.alarm_allowed = !no_tick_yet;
			no_tick_yet     = 1'b0;
		end
	endtask

	task automatic note_field(input string field, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s expected %0h actual %0h", field, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		slot_report_t predicted;
		if (!arst_n) begin
			awaited_reports.delete();
			monitored      = '0;
			reported_alive = '0;
			for (int i = 0; i < SlotMax; i++) slot_state[i] = SlotUnknown;
			clear_datagram();
			no_tick_yet    = 1'b1;
			mismatch_count = 0;
			reports_owed   = 0;
		end else begin
			if (enabled_slots_wr_en) monitored = enabled_slots_wr_data;
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_reports.size() == 0) begin
					$error("report word arrived with no report expected");
					mismatch_count++;
				end else begin
					predicted = awaited_reports.pop_front();
					note_field("report_kind", 16'(predicted.kind), 16'(m_axis_tuser));
					note_field("frame_status", 16'(predicted.status), 16'(m_axis_tdata[2:0]));
					note_field("ok_mask", predicted.ok_slots, m_axis_tdata[18:3]);
					note_field("fail_mask", predicted.lost_slots, m_axis_tdata[34:19]);
					note_field("alarm_allowed", 16'(predicted.alarm_allowed),
						16'(m_axis_tdata[35]));
					note_field("padding", 16'h0000, 16'(m_axis_tdata[39:36]));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predict_report(s_axis_tuser[0], s_axis_tdata, s_axis_tuser[1], s_axis_tlast,
					s_axis_tuser[2], predicted);
				awaited_reports.push_back(predicted);
			end
			reports_owed = awaited_reports.size();
		end
	end

endmodule

[sim/heartbeat_frame_slot_monitor_tb.sv]
// Top of the heartbeat monitor bench: stimulus, idling, watchdog and verdict.
module heartbeat_frame_slot_monitor_tb
	import hfsm_pkg::*;
();

	// Word kinds carried in tuser bit 0.
	localparam logic OpFrame = 1'b0;
	localparam logic OpTick  = 1'b1;

	// Roughly how many words the random part sends before it stops.
	localparam int RandomWords = 1550;

	// Cycles without any word moving on either stream before the run is
	// declared hung. The slowest healthy stretch is a sender gap plus a sink stall.
	localparam int StallLimit = 1000;

	// Ways a well-formed datagram gets broken on purpose.
	typedef enum int {
		FAULT_NONE,
		FAULT_FLAG,
		FAULT_CMD,
		FAULT_HDR_SUM,
		FAULT_SUM
	} fault_t;

	logic        clk = 1'b0;
	logic        arst_n;

	logic        enabled_slots_wr_en;
	logic [15:0] enabled_slots_wr_data;

	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // frame_byte
	logic        s_axis_tlast;   // last_of_frame
	logic [2:0]  s_axis_tuser;   // opcode, first_of_frame, refresh_due

	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // frame_status, ok_mask, fail_mask,
	                             // alarm_allowed, zero padding
	logic [2:0]  m_axis_tuser;   // report_kind

	int          mismatch_count;
	int          reports_owed;
	int          words_sent = 0;
	int          quiet_cycles = 0;
	bit          tx_steady = 1'b0;

	// Datagram under construction; bytes past the end of a long datagram are
	// drawn fresh when sent.
	logic [7:0]  dgram [FrameLength];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	heartbeat_frame_slot_monitor i_dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.enabled_slots_wr_en   (enabled_slots_wr_en),
		.enabled_slots_wr_data (enabled_slots_wr_data),
		.s_axis_tvalid         (s_axis_tvalid),
		.s_axis_tready         (s_axis_tready),
		.s_axis_tdata          (s_axis_tdata),
		.s_axis_tlast          (s_axis_tlast),
		.s_axis_tuser          (s_axis_tuser),
		.m_axis_tvalid         (m_axis_tvalid),
		.m_axis_tready         (m_axis_tready),
		.m_axis_tdata          (m_axis_tdata),
		.m_axis_tuser          (m_axis_tuser)
	);

	// The checker sees exactly what the block sees and hands back how many
	// fields went wrong and how many reports are still outstanding.
	heartbeat_frame_slot_monitor_check i_check (
		.clk                   (clk),
		.arst_n                (arst_n),
		.enabled_slots_wr_en   (enabled_slots_wr_en),
		.enabled_slots_wr_data (enabled_slots_wr_data),
		.s_axis_tvalid         (s_axis_tvalid),
		.s_axis_tready         (s_axis_tready),
		.s_axis_tdata          (s_axis_tdata),
		.s_axis_tlast          (s_axis_tlast),
		.s_axis_tuser          (s_axis_tuser),
		.m_axis_tvalid         (m_axis_tvalid),
		.m_axis_tready         (m_axis_tready),
		.m_axis_tdata          (m_axis_tdata),
		.m_axis_tuser          (m_axis_tuser),
		.mismatch_count        (mismatch_count),
		.reports_owed          (reports_owed)
	);

	// Each side draws its wait per word. Now and then it flips into a steady
	// mode with no waits at all, so back-to-back stretches show up as well.
	function automatic int draw_gap(inout bit steady);
		if ($urandom_range(0, 19) == 0) steady = !steady;
		return steady ? 0 : $urandom_range(0, 18);
	endfunction

	// Offers one word and holds it until the block takes it. valid is only
	// lowered when a gap is actually drawn, so it never drops and rises in
	// the same step.
	task automatic send_word(input logic opcode, input logic [7:0] data,
		input logic opens_frame, input logic is_last, input logic refresh);
		int gap;
		gap = draw_gap(tx_steady);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tlast  <= is_last;
		s_axis_tuser  <= {refresh, opens_frame, opcode};
		do @(posedge clk); while (!s_axis_tready);
		words_sent++;
	endtask

	// The byte, first and last fields of a tick are don't-care, so they are
	// randomized to toggle them anyway.
	task automatic send_tick(input logic refresh);
		send_word(OpTick, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), refresh);
	endtask

	// Stops offering words and waits until every report has come back. The
	// outstanding count is read at the falling edge so the checker has
	// already booked whatever moved at the last rising edge.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (reports_owed != 0);
		@(posedge clk);
	endtask

	// The register only changes while the stream is empty.
	task automatic write_enabled(input logic [15:0] value);
		drain();
		enabled_slots_wr_en   <= 1'b1;
		enabled_slots_wr_data <= value;
		@(posedge clk);
		enabled_slots_wr_en   <= 1'b0;
	endtask

	function automatic logic [7:0] pick_slots();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Fills in a datagram that passes every check, with the given alive bits
	// for slots 9-16 (high byte) and 1-8 (low byte).
	task automatic build_datagram(input logic [7:0] slots_hi, input logic [7:0] slots_lo);
		logic [7:0] running;
		dgram[PosFlag0]    = FlagByte;
		dgram[PosFlag1]    = FlagByte;
		dgram[PosFlagEnd]  = FlagEndByte;
		for (int k = 3; k < PosCmd0; k++) dgram[k] = 8'($urandom_range(0, 255));
		dgram[PosCmd0]     = CmdByte0;
		dgram[PosCmd1]     = CmdByte1;
		dgram[PosCmd1 + 1] = 8'($urandom_range(0, 255));
		dgram[PosHdrLast]  = 8'($urandom_range(0, 255));
		running = '0;
		for (int k = 0; k <= PosHdrLast; k++) running = running + dgram[k];
		dgram[PosHdrSum]   = running;
		dgram[PosSlotsHi]  = slots_hi;
		dgram[PosSlotsLo]  = slots_lo;
		dgram[PosSlotsLo + 1] = 8'($urandom_range(0, 255));
		dgram[PosSumLast]  = 8'($urandom_range(0, 255));
		for (int k = PosHdrSum; k <= PosSumLast; k++) running = running + dgram[k];
		dgram[PosSum]      = running;
	endtask

	// Sends the datagram cut or padded to len bytes. A tick can be slipped in
	// right after byte tick_at; pass -1 for none.
	task automatic send_datagram(input int len, input bit mark_first, input int tick_at);
		for (int k = 0; k < len; k++) begin
			send_word(OpFrame, (k < FrameLength) ? dgram[k] : 8'($urandom_range(0, 255)),
				mark_first && k == 0, k == len - 1, 1'($urandom_range(0, 1)));
			if (k == tick_at) send_tick(1'($urandom_range(0, 1)));
		end
	endtask

	// Sink side: a freshly drawn stall, which may be none, before every report word.
	initial begin
		bit rx_steady;
		int stall;
		rx_steady = 1'b0;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_gap(rx_steady);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Hang detection: nothing moved on either stream for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("heartbeat_frame_slot_monitor_tb failed");
			$finish;
		end
	end

	initial begin
		int     pick;
		int     len;
		int     tick_at;
		bit     mark_first;
		fault_t fault;
		logic [15:0] enables;

		s_axis_tvalid         <= 1'b0;
		s_axis_tdata          <= '0;
		s_axis_tlast          <= 1'b0;
		s_axis_tuser          <= '0;
		enabled_slots_wr_en   <= 1'b0;
		enabled_slots_wr_data <= '0;
		arst_n                <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. With no slot monitored, the very first tick asks for
		// a refresh and must come back quiet with alarms still held off.
		send_tick(1'b1);
		// A one-byte datagram: everything after byte 0 counts as zero and the
		// flag check fails first.
		send_word(OpFrame, 8'hFF, 1'b1, 1'b1, 1'b0);
		// Monitor every slot, then send a clean datagram marking all of them
		// alive with a tick slipped in after byte 5. That tick sees nothing
		// alive yet and must not disturb the datagram in flight.
		write_enabled(16'hFFFF);
		build_datagram(8'hFF, 8'hFF);
		send_datagram(FrameLength, 1'b1, 5);
		// The first tick after it reports all slots newly alive; the second
		// one reports all of them lost, since no datagram refreshed them.
		send_tick(1'b0);
		send_tick(1'b0);

		// Random part. Mostly well-formed datagrams with random content, some
		// broken on purpose, cut short or running long; ticks in between to
		// turn alive bits into reports; a little raw noise; and now and then
		// a register change or a full pause until the stream is empty.
		write_enabled(16'h0000);
		while (words_sent < RandomWords) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				build_datagram(pick_slots(), pick_slots());
				pick = $urandom_range(0, 9);
				fault = (pick < 6) ? FAULT_NONE : fault_t'(pick - 5);
				case (fault)
					FAULT_FLAG: dgram[$urandom_range(0, 2)] ^= 8'($urandom_range(1, 255));
					FAULT_CMD: dgram[$urandom_range(PosCmd0, PosCmd1)] ^=
						8'($urandom_range(1, 255));
					FAULT_HDR_SUM: dgram[PosHdrSum] ^= 8'($urandom_range(1, 255));
					FAULT_SUM: dgram[PosSum] ^= 8'($urandom_range(1, 255));
					default: ;
				endcase
				case ($urandom_range(0, 9))
					0: len = $urandom_range(1, FrameLength - 1);
					1: len = $urandom_range(FrameLength + 1, FrameLength + 7);
					default: len = FrameLength;
				endcase
				// Without a first marker the datagram relies on the previous
				// verdict having cleared the accumulators.
				mark_first = ($urandom_range(0, 5) != 0);
				tick_at = (len > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(0, len - 2) : -1;
				send_datagram(len, mark_first, tick_at);
			end else if (pick < 80) begin
				send_tick(1'($urandom_range(0, 1)));
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 6))
					send_word(OpFrame, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						$urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)));
			end else if (pick < 95) begin
				case ($urandom_range(0, 4))
					0: enables = 16'h0000;
					1: enables = 16'hFFFF;
					2: enables = 16'h0001 << $urandom_range(0, 15);
					default: enables = 16'($urandom_range(0, 16'hFFFF));
				endcase
				write_enabled(enables);
			end else begin
				drain();
			end
		end

		// Let every report come home, then give a late stray word a chance to
		// show up before judging.
		drain();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("heartbeat_frame_slot_monitor_tb passed");
		else
			$display("heartbeat_frame_slot_monitor_tb failed");
		$finish;
	end

endmodule
